>>> rtl/r10d_pkg.sv
// Shared types, constants and row tables for the relative-10 integer decoder.
// No dependencies; every other file in rtl/ imports this package.
package r10d_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned VALUE_W     = 30;
    localparam int unsigned LEN_W       = 32;
    localparam int unsigned ROW_W       = 4;
    localparam int unsigned FCOUNT_W    = 5;    // fields per word, at most 30
    localparam int unsigned FWIDTH_W    = 5;    // field width, at most 30
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [ROW_W-1:0] S9_ROWS  = 4'd9;
    localparam logic [LEN_W-1:0] LEN_RESET = 32'd1;

    typedef struct packed {
        logic [VALUE_W-1:0]  payload;
        logic [FWIDTH_W-1:0] width;
        logic [FCOUNT_W-1:0] count;
        logic                seq_end;   // last field of this job closes the sequence
    } r10d_job_t;

    function automatic logic [FCOUNT_W-1:0] s9_count(input logic [ROW_W-1:0] row);
        logic [FCOUNT_W-1:0] c;
        case (row)
            4'd0:    c = 5'd1;
            4'd1:    c = 5'd2;
            4'd2:    c = 5'd3;
            4'd3:    c = 5'd4;
            4'd4:    c = 5'd5;
            4'd5:    c = 5'd7;
            4'd6:    c = 5'd9;
            4'd7:    c = 5'd14;
            4'd8:    c = 5'd28;
            default: c = 5'd0;
        endcase
        return c;
    endfunction

    function automatic logic [FWIDTH_W-1:0] s9_bits(input logic [ROW_W-1:0] row);
        logic [FWIDTH_W-1:0] b;
        case (row)
            4'd0:    b = 5'd28;
            4'd1:    b = 5'd14;
            4'd2:    b = 5'd9;
            4'd3:    b = 5'd7;
            4'd4:    b = 5'd5;
            4'd5:    b = 5'd4;
            4'd6:    b = 5'd3;
            4'd7:    b = 5'd2;
            4'd8:    b = 5'd1;
            default: b = 5'd0;
        endcase
        return b;
    endfunction

    function automatic logic [FCOUNT_W-1:0] r10_count(input logic [ROW_W-1:0] row);
        logic [FCOUNT_W-1:0] c;
        case (row)
            4'd0:    c = 5'd1;
            4'd1:    c = 5'd2;
            4'd2:    c = 5'd3;
            4'd3:    c = 5'd4;
            4'd4:    c = 5'd5;
            4'd5:    c = 5'd6;
            4'd6:    c = 5'd7;
            4'd7:    c = 5'd10;
            4'd8:    c = 5'd15;
            default: c = 5'd30;
        endcase
        return c;
    endfunction

    function automatic logic [FWIDTH_W-1:0] r10_bits(input logic [ROW_W-1:0] row);
        logic [FWIDTH_W-1:0] b;
        case (row)
            4'd0:    b = 5'd30;
            4'd1:    b = 5'd15;
            4'd2:    b = 5'd10;
            4'd3:    b = 5'd7;
            4'd4:    b = 5'd6;
            4'd5:    b = 5'd5;
            4'd6:    b = 5'd4;
            4'd7:    b = 5'd3;
            4'd8:    b = 5'd2;
            default: b = 5'd1;
        endcase
        return b;
    endfunction

    // Transfer table: selector 0 steps up, 1 stays, 2 steps down, 3 drops to row 0.
    // Rows 0 to 2 behave as row 2, and rows 9 and above behave as row 8.
    function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] row,
                                                  input logic [1:0]       sel);
        logic [ROW_W-1:0] hi;
        logic [ROW_W-1:0] nr;
        case (row) inside
            4'd0, 4'd1, 4'd2: hi = 4'd3;
            [4'd3:4'd8]:      hi = row + 4'd1;
            default:          hi = 4'd9;
        endcase
        case (sel)
            2'd0:    nr = hi;
            2'd1:    nr = hi - 4'd1;
            2'd2:    nr = hi - 4'd2;
            default: nr = 4'd0;
        endcase
        return nr;
    endfunction

endpackage

>>> rtl/r10d_front.sv
// Front end: accepts packed words, resolves the row and field count, tracks the
// sequence counter and queues at most one unpack job per word. Depends on r10d_pkg.
module r10d_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [r10d_pkg::LEN_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [r10d_pkg::WORD_W-1:0] packed_word,
    input  logic                      starts_sequence,
    input  logic                      q_full,
    output logic                      q_push,
    output r10d_pkg::r10d_job_t       q_job
);
    import r10d_pkg::*;

    logic [LEN_W-1:0]    seq_len_reg;
    logic [LEN_W-1:0]    seq_len_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [LEN_W-1:0]    rem_reg;
    logic [LEN_W-1:0]    rem_next;

    logic                fire;
    logic                active;
    logic [ROW_W-1:0]    sel;
    logic [ROW_W-1:0]    row_sel;
    logic [LEN_W-1:0]    avail;
    logic [FCOUNT_W-1:0] fcount;
    logic [FWIDTH_W-1:0] fwidth;
    logic [VALUE_W-1:0]  payload;
    logic [FCOUNT_W-1:0] take;
    logic [LEN_W-1:0]    rem_after;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign fire      = in_valid && in_ready;
    assign sel       = packed_word[WORD_W-1 -: ROW_W];

    always_comb
    begin
        active  = 1'b0;
        row_sel = row_reg;
        avail   = '0;
        fcount  = '0;
        fwidth  = '0;
        payload = '0;
        if (starts_sequence)
        begin
            if (sel < S9_ROWS)
            begin
                active  = 1'b1;
                row_sel = sel;
                avail   = seq_len_reg;
                fcount  = s9_count(sel);
                fwidth  = s9_bits(sel);
                payload = {2'b00, packed_word[27:0]};
            end
        end
        else if (rem_reg != '0)
        begin
            active  = 1'b1;
            row_sel = next_row(row_reg, packed_word[WORD_W-1 -: 2]);
            avail   = rem_reg;
            fcount  = r10_count(row_sel);
            fwidth  = r10_bits(row_sel);
            payload = packed_word[VALUE_W-1:0];
        end
    end

    always_comb
    begin
        if (avail < LEN_W'(fcount))
            take = avail[FCOUNT_W-1:0];
        else
            take = fcount;
        rem_after = avail - LEN_W'(take);
    end

    always_comb
    begin
        seq_len_next = seq_len_reg;
        row_next     = row_reg;
        rem_next     = rem_reg;
        if (cfg_valid && cfg_ready)
            seq_len_next = cfg_data;
        if (fire)
        begin
            if (active)
            begin
                row_next = row_sel;
                rem_next = rem_after;
            end
            else if (starts_sequence)
                rem_next = '0;  // bad first selector kills the sequence
        end
    end

    assign q_push          = fire && active && (take != '0);
    assign q_job.payload   = payload;
    assign q_job.width     = fwidth;
    assign q_job.count     = take;
    assign q_job.seq_end   = (rem_after == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= LEN_RESET;
            row_reg     <= '0;
            rem_reg     <= '0;
        end
        else
        begin
            seq_len_reg <= seq_len_next;
            row_reg     <= row_next;
            rem_reg     <= rem_next;
        end
    end

endmodule

>>> rtl/r10d_queue.sv
// Short job queue between front and back end, built from flops.
// Depends on r10d_pkg for the job type.
module r10d_queue #(
    parameter int unsigned DEPTH = r10d_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  r10d_pkg::r10d_job_t push_job,
    output logic                full,
    input  logic                pop,
    output r10d_pkg::r10d_job_t pop_job,
    output logic                empty
);
    import r10d_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    r10d_job_t         slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (fill_reg == CNT_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

>>> rtl/r10d_back.sv
// Back end: takes one job from the queue and shifts out one field per cycle
// into the output register while the output is not stalled. Depends on r10d_pkg.
module r10d_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  r10d_pkg::r10d_job_t         q_job,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [r10d_pkg::VALUE_W-1:0] decoded_value,
    output logic                        last_of_word,
    output logic                        last_of_sequence
);
    import r10d_pkg::*;

    logic [VALUE_W-1:0]  shift_reg;
    logic [VALUE_W-1:0]  shift_next;
    logic [FWIDTH_W-1:0] width_reg;
    logic [FWIDTH_W-1:0] width_next;
    logic                seq_end_reg;
    logic                seq_end_next;
    logic [FCOUNT_W-1:0] left_reg;
    logic [FCOUNT_W-1:0] left_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [VALUE_W-1:0]  value_reg;
    logic [VALUE_W-1:0]  value_next;
    logic                low_reg;
    logic                low_next;
    logic                los_reg;
    logic                los_next;

    logic                advance;
    logic                last_field;
    logic [VALUE_W-1:0]  mask;

    assign advance    = (left_reg != '0) && (!out_valid_reg || out_ready);
    assign last_field = (left_reg == FCOUNT_W'(1));
    assign q_pop      = !q_empty && ((left_reg == '0) || (last_field && advance));
    assign mask       = VALUE_W'(((VALUE_W + 1)'(1) << width_reg) - (VALUE_W + 1)'(1));

    always_comb
    begin
        shift_next     = shift_reg;
        width_next     = width_reg;
        seq_end_next   = seq_end_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        low_next       = low_reg;
        los_next       = los_reg;

        if (out_ready)
            out_valid_next = 1'b0;
        if (advance)
        begin
            out_valid_next = 1'b1;
            value_next     = shift_reg & mask;
            low_next       = last_field;
            los_next       = last_field && seq_end_reg;
            shift_next     = shift_reg >> width_reg;
            left_next      = left_reg - 1'b1;
        end
        if (q_pop)
        begin
            shift_next   = q_job.payload;
            width_next   = q_job.width;
            seq_end_next = q_job.seq_end;
            left_next    = q_job.count;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        width_reg   <= width_next;
        seq_end_reg <= seq_end_next;
        value_reg   <= value_next;
        low_reg     <= low_next;
        los_reg     <= los_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign decoded_value    = value_reg;
    assign last_of_word     = low_reg;
    assign last_of_sequence = los_reg;

endmodule

>>> rtl/relative10_integer_decoder_top.sv
// Top level of the relative-10 word-aligned integer decoder.
// Depends on r10d_pkg, r10d_front, r10d_queue and r10d_back.
//
//   channel  handshake              payload
//   cfg      cfg_valid / cfg_ready  cfg_data (sequence_length)
//   in       in_valid / in_ready    packed_word, starts_sequence
//   out      out_valid / out_ready  decoded_value, last_of_word, last_of_sequence
//
// The front end takes one word per cycle while the job queue has room.
// The back end gives one integer per cycle unless out_ready stalls; a word of n
// fields (up to 30) passes a queue slot and the back-end registers before out_valid.
// Reset clears the row and the counter and sets sequence_length to 1.
// A stalled output holds its register; the queue lets the front keep going.
module relative10_integer_decoder_top #(
    parameter int unsigned QUEUE_DEPTH = r10d_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [r10d_pkg::LEN_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [r10d_pkg::WORD_W-1:0]   packed_word,
    input  logic                          starts_sequence,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [r10d_pkg::VALUE_W-1:0]  decoded_value,
    output logic                          last_of_word,
    output logic                          last_of_sequence
);
    import r10d_pkg::*;

    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;
    r10d_job_t push_job;
    r10d_job_t pop_job;

    r10d_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .packed_word     (packed_word),
        .starts_sequence (starts_sequence),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_job           (push_job)
    );

    r10d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    r10d_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_job            (pop_job),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .decoded_value    (decoded_value),
        .last_of_word     (last_of_word),
        .last_of_sequence (last_of_sequence)
    );

endmodule

>>> bench/tb_top.sv
// Self-checking bench for relative10_integer_decoder_top: directed and random word streams,
// with a bit-accurate unpacker that predicts every integer and its end-of-word/sequence flags.
// Depends on rtl/r10d_pkg.sv and the decoder RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned QUIET_CYCLES = 12;
    localparam int unsigned RANDOM_WORDS = 400;

    // Continuation selector codes (top two bits of a later word)
    localparam logic [1:0] SEL_UP      = 2'd0;
    localparam logic [1:0] SEL_STAY    = 2'd1;
    localparam logic [1:0] SEL_DOWN    = 2'd2;
    localparam logic [1:0] SEL_RESTART = 2'd3;

    localparam int unsigned S9_FIELDS [9]  = '{1, 2, 3, 4, 5, 7, 9, 14, 28};
    localparam int unsigned S9_WIDTH  [9]  = '{28, 14, 9, 7, 5, 4, 3, 2, 1};
    localparam int unsigned R10_FIELDS [10] = '{1, 2, 3, 4, 5, 6, 7, 10, 15, 30};
    localparam int unsigned R10_WIDTH  [10] = '{30, 15, 10, 7, 6, 5, 4, 3, 2, 1};
    localparam logic [3:0] ROW_STEP [10][4] = '{
        '{4'd3, 4'd2, 4'd1, 4'd0}, '{4'd3, 4'd2, 4'd1, 4'd0}, '{4'd3, 4'd2, 4'd1, 4'd0},
        '{4'd4, 4'd3, 4'd2, 4'd0}, '{4'd5, 4'd4, 4'd3, 4'd0}, '{4'd6, 4'd5, 4'd4, 4'd0},
        '{4'd7, 4'd6, 4'd5, 4'd0}, '{4'd8, 4'd7, 4'd6, 4'd0}, '{4'd9, 4'd8, 4'd7, 4'd0},
        '{4'd9, 4'd8, 4'd7, 4'd0}};

    typedef struct packed {
        logic [r10d_pkg::VALUE_W-1:0] value;
        logic                         word_end;
        logic                         seq_end;
    } decoded_int_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [r10d_pkg::LEN_W-1:0]     cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic [r10d_pkg::WORD_W-1:0]    packed_word;
    logic                           starts_sequence;
    logic                           out_valid;
    logic                           out_ready;
    logic [r10d_pkg::VALUE_W-1:0]   decoded_value;
    logic                           last_of_word;
    logic                           last_of_sequence;

    // Predictor state
    logic [31:0]    run_length;
    logic [31:0]    remaining;
    logic [3:0]     cur_row;
    decoded_int_t   pending_ints [$];

    bit             steady;
    int unsigned    errors;
    int unsigned    words_used;
    int unsigned    words_sent;
    int unsigned    ints_checked;
    int unsigned    lengths_written;
    int unsigned    cycle_count;

    relative10_integer_decoder_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .packed_word      (packed_word),
        .starts_sequence  (starts_sequence),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .decoded_value    (decoded_value),
        .last_of_word     (last_of_word),
        .last_of_sequence (last_of_sequence)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d integers outstanding", $time, pending_ints.size());
            $display("relative10_integer_decoder_top test failed");
            $finish;
        end
    end

    // Unpacks one accepted word into expected integers; returns 0 if the word is ignored.
    function automatic bit unpack_word(input logic [31:0] w, input logic s);
        logic [3:0]     row;
        logic [31:0]    body;
        logic [31:0]    mask;
        int unsigned    fields;
        int unsigned    width;
        int unsigned    n;
        decoded_int_t   d;
        if (s)
        begin
            if (w[31:28] >= r10d_pkg::S9_ROWS)
            begin
                remaining = '0;
                return 1'b1;
            end
            remaining = run_length;
            cur_row   = w[31:28];
            body      = {4'h0, w[27:0]};
            fields    = S9_FIELDS[cur_row];
            width     = S9_WIDTH[cur_row];
        end
        else
        begin
            if (remaining == 0)
                return 1'b0;
            row     = (cur_row > 4'd9) ? 4'd9 : cur_row;
            cur_row = ROW_STEP[row][w[31:30]];
            body    = {2'b00, w[29:0]};
            fields  = R10_FIELDS[cur_row];
            width   = R10_WIDTH[cur_row];
        end
        n = fields;
        if (remaining < n)
            n = remaining;
        mask = (32'd1 << width) - 32'd1;
        for (int unsigned k = 0; k < n; k++)
        begin
            remaining  = remaining - 32'd1;
            d.value    = 30'((body >> (k * width)) & mask);
            d.word_end = (k + 1 == n);
            d.seq_end  = (remaining == 0);
            pending_ints.insert(pending_ints.size(), d);
        end
        return 1'b1;
    endfunction

    // Mostly random, with the odd all-zeros or all-ones word
    function automatic logic [31:0] random_bits();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] random_length();
        case ($urandom_range(0, 9))
            0:       return 32'd1;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3, 4:    return $urandom_range(1, 8);
            5, 6:    return $urandom_range(1, 64);
            default: return $urandom_range(1, 400);
        endcase
    endfunction

    task automatic send_word(input logic [31:0] w, input logic s);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        packed_word     <= w;
        starts_sequence <= s;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        if (unpack_word(w, s))
            words_used++;
    endtask

    // Wait until every predicted integer is out and the pipeline has gone quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_ints.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [31:0] len);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        run_length  = len;
        lengths_written++;
    endtask

    task automatic test_reset_length();
        // Reset length is one: a single integer, then the follow-on word is dropped
        send_word({4'd0, 28'hFFF_FFFF}, 1'b1);
        send_word({SEL_STAY, 30'h3FFF_FFFF}, 1'b0);
    endtask

    task automatic test_all_rows();
        write_length(32'hFFFF_FFFF);
        send_word({4'd0, 28'h000_0000}, 1'b1);
        send_word({4'd1, 28'hFFF_FFFF}, 1'b1);
        send_word({4'd2, 28'hAAA_AAAA}, 1'b1);
        send_word({4'd3, 28'h555_5555}, 1'b1);
        send_word({4'd4, 28'(random_bits())}, 1'b1);
        send_word({4'd5, 28'hFFF_FFFF}, 1'b1);
        send_word({4'd6, 28'(random_bits())}, 1'b1);
        send_word({4'd7, 28'h555_5555}, 1'b1);
        send_word({4'd8, 28'hAAA_AAAA}, 1'b1);
        // walk the transfer table: up into the top row, stay there, then down and restart
        send_word({SEL_UP, 30'h3FFF_FFFF}, 1'b0);
        send_word({SEL_UP, 30'h2AAA_AAAA}, 1'b0);
        send_word({SEL_STAY, 30'h1555_5555}, 1'b0);
        send_word({SEL_DOWN, 30'h3FFF_FFFF}, 1'b0);
        send_word({SEL_RESTART, 30'h3FFF_FFFF}, 1'b0);
        send_word({SEL_UP, 30'(random_bits())}, 1'b0);
    endtask

    task automatic test_bad_selector();
        send_word({4'd9, 28'(random_bits())}, 1'b1);
        send_word({SEL_UP, 30'(random_bits())}, 1'b0);
        send_word({4'd15, 28'hFFF_FFFF}, 1'b1);
    endtask

    task automatic test_count_inside_word();
        // Only the first five fields of a 28-field word come out
        write_length(32'd5);
        send_word({4'd8, 28'hFFF_FFFF}, 1'b1);
        send_word({SEL_STAY, 30'h3FFF_FFFF}, 1'b0);
    endtask

    task automatic test_zero_length();
        write_length(32'd0);
        send_word({4'd3, 28'(random_bits())}, 1'b1);
        send_word({SEL_UP, 30'(random_bits())}, 1'b0);
        write_length(32'd1);
    endtask

    task automatic test_random_sequences();
        int unsigned start_sent;
        int unsigned pick;
        int unsigned conts;
        start_sent = words_sent;
        while (words_sent - start_sent < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                write_length(random_length());
            steady = ($urandom_range(0, 4) == 0);
            if (pick >= 80)
            begin
                // noise: bad selectors and stray words with random start flags
                repeat ($urandom_range(1, 4))
                    if ($urandom_range(0, 1) == 1)
                        send_word({4'($urandom_range(9, 15)), 28'(random_bits())}, 1'b1);
                    else
                        send_word(random_bits(), 1'($urandom_range(0, 1)));
            end
            else
            begin
                send_word({4'($urandom_range(0, 8)), 28'(random_bits())}, 1'b1);
                conts = $urandom_range(0, 12);
                repeat (conts)
                    send_word(random_bits(), 1'b0);
            end
        end
        steady = 1'b0;
    endtask

    // Result side: random stalls, each transaction compared with the oldest prediction
    initial
    begin : result_checker
        int unsigned    stall;
        decoded_int_t   want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 10);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (pending_ints.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected integer, expected none, actual %h",
                         $time, decoded_value);
            end
            else
            begin
                want = pending_ints.pop_front();
                ints_checked++;
                if (decoded_value !== want.value)
                begin
                    errors++;
                    $display("%0t: decoded_value expected %h actual %h",
                             $time, want.value, decoded_value);
                end
                if (last_of_word !== want.word_end)
                begin
                    errors++;
                    $display("%0t: last_of_word expected %b actual %b",
                             $time, want.word_end, last_of_word);
                end
                if (last_of_sequence !== want.seq_end)
                begin
                    errors++;
                    $display("%0t: last_of_sequence expected %b actual %b",
                             $time, want.seq_end, last_of_sequence);
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        packed_word     = '0;
        starts_sequence = 1'b0;
        out_ready       = 1'b0;
        run_length      = r10d_pkg::LEN_RESET;
        remaining       = '0;
        cur_row         = '0;
        steady          = 1'b0;
        errors          = 0;
        words_used      = 0;
        words_sent      = 0;
        ints_checked    = 0;
        lengths_written = 0;
        cycle_count     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_length();
        test_all_rows();
        test_bad_selector();
        test_count_inside_word();
        test_zero_length();
        test_random_sequences();
        settle();

        $display("Decoded %0d words into %0d checked integers across %0d length settings,",
                 words_used, ints_checked, lengths_written);
        $display("including bad selectors, truncated words and zero-length sequences.");
        if (errors == 0)
            $display("relative10_integer_decoder_top test passed");
        else
            $display("relative10_integer_decoder_top test failed");
        $finish;
    end

endmodule
